/* src/smcr_pkg.sv */
// ----------------------------------------------------------------------------
// smcr_pkg
// Shared types, codes and constants of the stepper move/current regulator.
// ----------------------------------------------------------------------------
package smcr_pkg;

	// Command codes carried in the input tuser
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} smcr_cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_WORK_CURRENT  = 3'd0,
		REG_BRAKE_CURRENT = 3'd1,
		REG_LOW_THRESH    = 3'd2,
		REG_HIGH_THRESH   = 3'd3,
		REG_START_DELAY   = 3'd4,
		REG_MIN_DELAY     = 3'd5
	} smcr_reg_t;

	// Move and averaging constants
	localparam logic [9:0] FULL_TURN_STEPS = 10'd763;
	localparam int unsigned AVG_SAMPLES    = 4;
	localparam logic [2:0] AVG_CNT         = 3'(AVG_SAMPLES);
	// floor(sum / AVG_SAMPLES) == (sum * AVG_RECIP) >> AVG_SHIFT, exact for 12-bit sums
	localparam int unsigned AVG_SHIFT      = 17;
	localparam logic [17:0] AVG_RECIP      =
		18'(((1 << AVG_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES);

	// Ramp window: delay grows while fewer than this many steps remain
	localparam logic [9:0] RAMP_STEPS = 10'd5;
	localparam logic [9:0] PWM_MAX    = 10'd1023;
	localparam logic [7:0] DELAY_MAX  = 8'd255;
	// Averaging starts once more than this many steps of the move are done
	localparam logic [9:0] SETTLE_STEPS = 10'd3;

	// Reset values of the configuration registers
	localparam logic [9:0] WORK_CURRENT_RST  = 10'd60;
	localparam logic [9:0] BRAKE_CURRENT_RST = 10'd50;
	localparam logic [9:0] LOW_THRESH_RST    = 10'd25;
	localparam logic [9:0] HIGH_THRESH_RST   = 10'd30;
	localparam logic [7:0] START_DELAY_RST   = 8'd10;
	localparam logic [7:0] MIN_DELAY_RST     = 8'd5;

	// Full-step coil pattern: bit0 A1, bit1 A2, bit2 B1, bit3 B2
	function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
		logic [3:0] pat;
		unique case (phase)
			2'd0: pat = 4'b1010;
			2'd1: pat = 4'b1001;
			2'd2: pat = 4'b0101;
			2'd3: pat = 4'b0110;
			default: pat = 4'b1010;
		endcase
		return pat;
	endfunction

endpackage

/* src/stepper_move_current_regulator.sv */
// ----------------------------------------------------------------------------
// stepper_move_current_regulator
// Full-step two-phase stepper sequencer with phase current regulation and
// a step-delay ramp.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one request per start or step tick. s_tuser is the
//    command (0 start a move, 1 step tick); s_tdata carries the move and
//    sample fields. Every request yields exactly one result.
//  - Output stream (m_*): coil drive, both phase PWM values, next step delay
//    and a step-taken flag in m_tdata; m_tlast marks the result that ends
//    a move (drive then falls to the brake current).
//  - Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one register per
//    cycle, no read-back; write only while the stream is idle.
//  - Path: a request accepted on s_* is held in the input register, then
//    in the result register, from which m_* is driven.
//  - Throughput: one request per cycle unless stalled; a request's work
//    is one pass through the step/regulation logic between the two registers.
//  - Stall: with m_tready low, the result holds and one more request can be
//    taken into the input register; s_tready then drops until m_tready rises.
//  - Reset (arst_n low): move state, averager and PWM values clear, the
//    configuration registers return to their defaults, both streams empty.
// ----------------------------------------------------------------------------
module stepper_move_current_regulator
	import smcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] direction, [10:1] step_count, [11] home_search, [21:12] adc_sample,
	// [22] home_sensor, [23] zero
	input  logic [23:0] s_tdata,
	// [0] command
	input  logic        s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] coil_drive, [13:4] pwm_phase_a, [23:14] pwm_phase_b,
	// [31:24] step_delay, [32] step_taken, [39:33] zero
	output logic [39:0] m_tdata,
	// move_done
	output logic        m_tlast
);

	// Configuration registers
	logic [9:0] work_cur_q, brake_cur_q, low_thr_q, high_thr_q;
	logic [7:0] start_dly_q, min_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_cur_q  <= WORK_CURRENT_RST;
			brake_cur_q <= BRAKE_CURRENT_RST;
			low_thr_q   <= LOW_THRESH_RST;
			high_thr_q  <= HIGH_THRESH_RST;
			start_dly_q <= START_DELAY_RST;
			min_dly_q   <= MIN_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WORK_CURRENT:  work_cur_q  <= cfg_wdata;
				REG_BRAKE_CURRENT: brake_cur_q <= cfg_wdata;
				REG_LOW_THRESH:    low_thr_q   <= cfg_wdata;
				REG_HIGH_THRESH:   high_thr_q  <= cfg_wdata;
				REG_START_DELAY:   start_dly_q <= cfg_wdata[7:0];
				REG_MIN_DELAY:     min_dly_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Input register stage
	logic        valid_s1;
	smcr_cmd_t   cmd_s1;
	logic        dir_s1, home_s1, sensor_s1;
	logic [9:0]  count_s1, sample_s1;
	logic        adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= smcr_cmd_t'(s_tuser);
			dir_s1    <= s_tdata[0];
			count_s1  <= s_tdata[10:1];
			home_s1   <= s_tdata[11];
			sample_s1 <= s_tdata[21:12];
			sensor_s1 <= s_tdata[22];
		end
	end

	// Move state
	logic        moving_q, move_dir_q, homing_q, reg_b_q;
	logic [9:0]  step_target_q, step_idx_q, pwm_a_q, pwm_b_q;
	logic [1:0]  phase_q;
	logic [7:0]  delay_q;
	logic [11:0] adc_sum_q;
	logic [2:0]  adc_cnt_q;

	// Next-state and result values
	logic        moving_n, move_dir_n, homing_n, reg_b_n;
	logic [9:0]  step_target_n, step_idx_n, pwm_a_n, pwm_b_n;
	logic [1:0]  phase_n;
	logic [7:0]  delay_n;
	logic [11:0] adc_sum_n;
	logic [2:0]  adc_cnt_n;
	logic [9:0]  pa, pb;
	logic        taken, done;

	// Averager and PWM adjust helpers
	logic [11:0] sum_acc;
	logic [2:0]  cnt_acc;
	logic [29:0] avg_prod;
	logic [9:0]  avg;
	logic [9:0]  adj_in, adj_dec, adj_out;
	logic [9:0]  start_target, remain;

	assign sum_acc  = adc_sum_q + {2'b00, sample_s1};
	assign cnt_acc  = adc_cnt_q + 3'd1;
	assign avg_prod = 30'(sum_acc) * 30'(AVG_RECIP);
	assign avg      = avg_prod[AVG_SHIFT +: 10];

	// decrement first, then increment, each clamped
	assign adj_in  = reg_b_q ? pwm_b_q : pwm_a_q;
	assign adj_dec = ({2'b00, avg} > {2'b00, high_thr_q} && adj_in != 10'd0)
		? adj_in - 10'd1 : adj_in;
	assign adj_out = (avg < low_thr_q && adj_dec != PWM_MAX) ? adj_dec + 10'd1 : adj_dec;

	assign start_target = home_s1 ? FULL_TURN_STEPS : count_s1;
	assign remain       = step_target_q - step_idx_q;

	// One pass of the step / start logic
	always_comb begin
		moving_n      = moving_q;
		move_dir_n    = move_dir_q;
		homing_n      = homing_q;
		reg_b_n       = reg_b_q;
		step_target_n = step_target_q;
		step_idx_n    = step_idx_q;
		pwm_a_n       = pwm_a_q;
		pwm_b_n       = pwm_b_q;
		phase_n       = phase_q;
		delay_n       = delay_q;
		adc_sum_n     = adc_sum_q;
		adc_cnt_n     = adc_cnt_q;
		pa            = brake_cur_q;
		pb            = brake_cur_q;
		taken         = 1'b0;
		done          = 1'b0;

		priority if (cmd_s1 == CMD_START) begin
			move_dir_n    = dir_s1;
			homing_n      = home_s1;
			step_target_n = start_target;
			step_idx_n    = 10'd0;
			delay_n       = start_dly_q;
			pwm_a_n       = work_cur_q;
			pwm_b_n       = work_cur_q;
			adc_sum_n     = 12'd0;
			adc_cnt_n     = 3'd0;
			if (start_target == 10'd0) begin
				moving_n = 1'b0;
				done     = 1'b1;
			end else begin
				moving_n = 1'b1;
				pa       = work_cur_q;
				pb       = work_cur_q;
			end
		end else if (moving_q) begin
			if (homing_q && sensor_s1) begin
				// home found: stop without stepping
				moving_n = 1'b0;
				done     = 1'b1;
			end else begin
				// current averaging after the first few steps
				if (step_idx_q > SETTLE_STEPS) begin
					adc_sum_n = sum_acc;
					adc_cnt_n = cnt_acc;
					if (cnt_acc == AVG_CNT) begin
						if (reg_b_q) begin
							pwm_b_n = adj_out;
						end else begin
							pwm_a_n = adj_out;
						end
						adc_sum_n = 12'd0;
						adc_cnt_n = 3'd0;
						reg_b_n   = !reg_b_q;
					end
				end
				pa = pwm_a_n;
				pb = pwm_b_n;
				phase_n = move_dir_q ? phase_q + 2'd1 : phase_q - 2'd1;
				// delay ramp: slow down near the end, speed up otherwise
				if (remain < RAMP_STEPS) begin
					if (delay_q != DELAY_MAX) begin
						delay_n = delay_q + 8'd1;
					end
				end else if (delay_q > min_dly_q) begin
					delay_n = delay_q - 8'd1;
				end
				step_idx_n = step_idx_q + 10'd1;
				taken      = 1'b1;
				if (step_idx_n >= step_target_q) begin
					moving_n = 1'b0;
					done     = 1'b1;
				end
			end
		end else begin
			// idle step tick: report brake current only
			done = 1'b0;
		end
	end

	// State update when a request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q      <= 1'b0;
			move_dir_q    <= 1'b0;
			homing_q      <= 1'b0;
			reg_b_q       <= 1'b0;
			step_target_q <= 10'd0;
			step_idx_q    <= 10'd0;
			pwm_a_q       <= 10'd0;
			pwm_b_q       <= 10'd0;
			phase_q       <= 2'd0;
			delay_q       <= 8'd0;
			adc_sum_q     <= 12'd0;
			adc_cnt_q     <= 3'd0;
		end else if (adv) begin
			moving_q      <= moving_n;
			move_dir_q    <= move_dir_n;
			homing_q      <= homing_n;
			reg_b_q       <= reg_b_n;
			step_target_q <= step_target_n;
			step_idx_q    <= step_idx_n;
			pwm_a_q       <= pwm_a_n;
			pwm_b_q       <= pwm_b_n;
			phase_q       <= phase_n;
			delay_q       <= delay_n;
			adc_sum_q     <= adc_sum_n;
			adc_cnt_q     <= adc_cnt_n;
		end
	end

	// Result register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {7'd0, taken, delay_n, pb, pa, coil_pattern(phase_n)};
			out_last_q <= done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// A running move never has reached its target
	a_idx_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> step_idx_q < step_target_q)
		else $error("step index reached target while moving");

	// The averager empties before it holds a full group
	a_avg_count: assert property (@(posedge clk) disable iff (!arst_n)
		adc_cnt_q < AVG_CNT)
		else $error("averager count overflow");

	// An advanced request always shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("advanced request produced no result");

	// A request stuck in the input register keeps its command
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("held request changed");
`endif

endmodule
